>>> rtl/core/brb_pkg.sv
// Shared types and constants for the byte ring buffer with rewind.
// Used by the top level; has no dependencies of its own.
package brb_pkg;

	parameter int unsigned DEPTH     = 4096;
	parameter int unsigned ADDR_W    = $clog2(DEPTH);
	parameter int unsigned CNT_W     = 13;
	parameter int unsigned ALU_W     = 14;
	parameter int unsigned LEN_W     = 7;
	parameter int unsigned MAX_CHUNK = 64;

	typedef enum logic [2:0] {
		KIND_WR_REQ  = 3'd0,
		KIND_WR_DATA = 3'd1,
		KIND_READ    = 3'd2,
		KIND_SKIP    = 3'd3,
		KIND_CLEAR   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_REFUSED = 2'd1,
		STATUS_DATA    = 2'd2
	} status_t;

	typedef enum logic {
		REG_CAPACITY = 1'b0,
		REG_HISTORY  = 1'b1
	} reg_index_t;

endpackage

>>> rtl/core/byte_ring_buffer_with_rewind.sv
// Top level of the byte ring buffer with a rewindable history window.
// Depends on brb_pkg and brb_ram.
//
// Channel | Direction | Handshake          | Beat contents
// in      | input     | in_valid/in_ready   | kind, chunk_length, data_byte, skip_amount
// out     | output    | out_valid/out_ready | status, read_byte, last, moved, counts
// cfg     | input     | APB psel/penable    | capacity_in_use, history_limit
//
// One shared 14-bit add/subtract unit does most count, compare and pointer updates.
// A non-read command runs S_USED, S_WRT, S_DECODE, any update states, S_USED, S_WRT and S_EMIT;
// a read of n bytes gives n beats, since each byte needs a state at the RAM port (S_RD_ADDR)
// and one ALU pointer update (S_RD_DATA). The next beat is taken only back in S_IDLE.
// The input is not ready until the last beat of the current command is in the output register.
// A stalled output holds the sequencer; the reset is asynchronous and empties the ring.
module byte_ring_buffer_with_rewind (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [6:0]  chunk_length,
	input  logic [7:0]  data_byte,
	input  logic signed [13:0] skip_amount,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  read_byte,
	output logic        last,
	output logic [12:0] moved,
	output logic [12:0] readable_count,
	output logic [12:0] writable_count,
	output logic [12:0] history_count,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_USED,
		S_WRT,
		S_DECODE,
		S_WRAP,
		S_RPF1,
		S_RPF2,
		S_FILLB,
		S_RPB1,
		S_RPB2,
		S_BACK,
		S_BCLAMP,
		S_EMIT,
		S_RD_ADDR,
		S_RD_DATA
	} state_t;

	localparam int unsigned AW = brb_pkg::ADDR_W;
	localparam int unsigned CW = brb_pkg::CNT_W;
	localparam int unsigned XW = brb_pkg::ALU_W;
	localparam int unsigned LW = brb_pkg::LEN_W;

	state_t                 state_q;
	logic                   post_q;
	brb_pkg::kind_t         kind_q;
	logic [LW-1:0]          len_q;
	logic [7:0]             byte_q;
	logic                   neg_q;
	logic [XW-1:0]          amt_q;
	logic [AW-1:0]          rp_q;
	logic [AW-1:0]          wp_q;
	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          back_q;
	logic [LW-1:0]          pend_q;
	logic [CW-1:0]          cap_q;
	logic [CW-1:0]          hlim_q;
	logic [CW-1:0]          size_q;
	logic [CW-1:0]          wr_q;
	logic [XW-1:0]          tmp_q;
	logic                   borrow_q;
	logic                   reading_q;
	logic [LW-1:0]          cnt_q;
	brb_pkg::status_t       res_status_q;
	logic [CW-1:0]          res_moved_q;

	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [7:0]             read_byte_q;
	logic                   last_q;
	logic [CW-1:0]          moved_q;
	logic [CW-1:0]          readable_q;
	logic [CW-1:0]          writable_q;
	logic [CW-1:0]          history_q;

	logic [XW-1:0]          alu_a;
	logic [XW-1:0]          alu_b;
	logic                   alu_sub;
	logic [XW:0]            alu_res;
	logic [XW-1:0]          alu_val;
	logic                   alu_borrow;

	logic                   out_free;
	logic                   out_load;
	logic                   cfg_wr;
	logic [CW-1:0]          cfg_val;
	logic [CW-1:0]          cfg_size;
	logic                   data_ok;
	logic                   len_big;
	logic                   ram_we;
	logic                   ram_re;
	logic [AW-1:0]          ram_addr;
	logic [7:0]             ram_rdata;

	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && ((state_q == S_EMIT) || (state_q == S_RD_DATA));
	assign in_ready = (state_q == S_IDLE);
	assign len_big  = ({1'b0, len_q} > (LW+1)'(brb_pkg::MAX_CHUNK));
	assign data_ok  = (pend_q != '0);

	assign cfg_wr   = psel && penable && pwrite;
	assign cfg_val  = pwdata[CW-1:0];
	assign cfg_size = (cfg_val == '0) ? CW'(1) :
		((cfg_val > CW'(brb_pkg::DEPTH)) ? CW'(brb_pkg::DEPTH) : cfg_val);
	assign pready   = 1'b1;

	always_comb begin
		unique case (brb_pkg::reg_index_t'(paddr[2]))
			brb_pkg::REG_CAPACITY: prdata = {{(32-CW){1'b0}}, cap_q};
			brb_pkg::REG_HISTORY:  prdata = {{(32-CW){1'b0}}, hlim_q};
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		unique case (state_q)
			S_USED: begin
				alu_a   = XW'(fill_q);
				alu_b   = XW'(back_q);
				alu_sub = 1'b0;
			end
			S_WRT: begin
				alu_a = XW'(size_q);
				alu_b = tmp_q;
			end
			S_DECODE: begin
				case (kind_q)
					brb_pkg::KIND_WR_REQ: begin
						alu_a = XW'(wr_q);
						alu_b = XW'(len_q);
					end
					brb_pkg::KIND_READ: begin
						alu_a = XW'(fill_q);
						alu_b = XW'(len_q);
					end
					brb_pkg::KIND_SKIP: begin
						alu_a = neg_q ? XW'(back_q) : XW'(fill_q);
						alu_b = amt_q;
					end
					default: begin
						alu_a = '0;
						alu_b = '0;
					end
				endcase
			end
			S_WRAP: begin
				alu_a = XW'(wp_q) + XW'(1);
				alu_b = XW'(size_q);
			end
			S_RPF1: begin
				alu_a   = XW'(rp_q);
				alu_b   = amt_q;
				alu_sub = 1'b0;
			end
			S_RPF2: begin
				alu_a = tmp_q;
				alu_b = XW'(size_q);
			end
			S_FILLB: begin
				alu_a   = XW'(fill_q);
				alu_b   = amt_q;
				alu_sub = 1'b0;
			end
			S_RPB1: begin
				alu_a = XW'(rp_q);
				alu_b = amt_q;
			end
			S_RPB2: begin
				alu_a   = tmp_q;
				alu_b   = XW'(size_q);
				alu_sub = 1'b0;
			end
			S_BACK: begin
				alu_a   = XW'(back_q);
				alu_b   = XW'(len_q);
				alu_sub = 1'b0;
			end
			S_BCLAMP: begin
				alu_a = XW'(hlim_q);
				alu_b = tmp_q;
			end
			S_RD_DATA: begin
				alu_a = XW'(rp_q) + XW'(1);
				alu_b = XW'(size_q);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                            : ({1'b0, alu_a} + {1'b0, alu_b});
	assign alu_val    = alu_res[XW-1:0];
	assign alu_borrow = alu_res[XW];

	assign ram_we   = (state_q == S_DECODE) && (kind_q == brb_pkg::KIND_WR_DATA) && data_ok;
	assign ram_re   = (state_q == S_RD_ADDR);
	assign ram_addr = (state_q == S_DECODE) ? wp_q : rp_q;

	brb_ram #(
		.WIDTH (8),
		.DEPTH (brb_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (byte_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			post_q       <= 1'b0;
			kind_q       <= brb_pkg::KIND_WR_REQ;
			rp_q         <= '0;
			wp_q         <= '0;
			fill_q       <= '0;
			back_q       <= '0;
			pend_q       <= '0;
			cap_q        <= CW'(brb_pkg::DEPTH);
			size_q       <= CW'(brb_pkg::DEPTH);
			hlim_q       <= '0;
			wr_q         <= '0;
			reading_q    <= 1'b0;
			cnt_q        <= '0;
			res_status_q <= brb_pkg::STATUS_DONE;
			res_moved_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q    <= brb_pkg::kind_t'(kind);
						len_q     <= chunk_length;
						byte_q    <= data_byte;
						neg_q     <= skip_amount[XW-1];
						amt_q     <= skip_amount[XW-1] ? (XW'(0) - skip_amount)
						                               : skip_amount;
						post_q    <= 1'b0;
						reading_q <= 1'b0;
						state_q   <= S_USED;
					end
				end
				S_USED: begin
					tmp_q   <= alu_val;
					state_q <= S_WRT;
				end
				S_WRT: begin
					wr_q <= alu_borrow ? '0 : alu_val[CW-1:0];
					if (!post_q) begin
						state_q <= S_DECODE;
					end else if (reading_q) begin
						state_q <= S_RD_ADDR;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_DECODE: begin
					post_q       <= 1'b1;
					res_status_q <= brb_pkg::STATUS_REFUSED;
					res_moved_q  <= '0;
					state_q      <= S_USED;
					if (kind_q == brb_pkg::KIND_CLEAR) begin
						rp_q         <= '0;
						wp_q         <= '0;
						fill_q       <= '0;
						back_q       <= '0;
						pend_q       <= '0;
						res_status_q <= brb_pkg::STATUS_DONE;
					end else if (kind_q == brb_pkg::KIND_WR_DATA) begin
						if (data_ok) begin
							fill_q       <= fill_q + CW'(1);
							pend_q       <= pend_q - LW'(1);
							res_status_q <= brb_pkg::STATUS_DONE;
							res_moved_q  <= CW'(1);
							state_q      <= S_WRAP;
						end
					end else if (data_ok) begin
						res_status_q <= brb_pkg::STATUS_REFUSED;
					end else begin
						case (kind_q)
							brb_pkg::KIND_WR_REQ: begin
								if (!len_big && !alu_borrow) begin
									pend_q       <= len_q;
									res_status_q <= brb_pkg::STATUS_DONE;
									res_moved_q  <= CW'(len_q);
								end
							end
							brb_pkg::KIND_READ: begin
								if (!len_big && !alu_borrow) begin
									res_status_q <= brb_pkg::STATUS_DONE;
									if (len_q != '0) begin
										fill_q       <= alu_val[CW-1:0];
										res_status_q <= brb_pkg::STATUS_DATA;
										res_moved_q  <= CW'(len_q);
										cnt_q        <= len_q;
										reading_q    <= 1'b1;
										state_q      <= S_BACK;
									end
								end
							end
							brb_pkg::KIND_SKIP: begin
								if (!alu_borrow) begin
									res_status_q <= brb_pkg::STATUS_DONE;
									res_moved_q  <= amt_q[CW-1:0];
									if (neg_q) begin
										back_q  <= alu_val[CW-1:0];
										state_q <= S_FILLB;
									end else begin
										fill_q  <= alu_val[CW-1:0];
										state_q <= S_RPF1;
									end
								end
							end
							default: begin
								res_status_q <= brb_pkg::STATUS_REFUSED;
							end
						endcase
					end
				end
				S_WRAP: begin
					wp_q    <= alu_borrow ? alu_a[AW-1:0] : '0;
					state_q <= S_USED;
				end
				S_RPF1: begin
					tmp_q   <= alu_val;
					state_q <= S_RPF2;
				end
				S_RPF2: begin
					rp_q    <= alu_borrow ? tmp_q[AW-1:0] : alu_val[AW-1:0];
					state_q <= S_USED;
				end
				S_FILLB: begin
					fill_q  <= alu_val[CW-1:0];
					state_q <= S_RPB1;
				end
				S_RPB1: begin
					tmp_q    <= alu_val;
					borrow_q <= alu_borrow;
					state_q  <= S_RPB2;
				end
				S_RPB2: begin
					rp_q    <= borrow_q ? alu_val[AW-1:0] : tmp_q[AW-1:0];
					state_q <= S_USED;
				end
				S_BACK: begin
					tmp_q   <= alu_val;
					state_q <= S_BCLAMP;
				end
				S_BCLAMP: begin
					back_q  <= alu_borrow ? hlim_q : tmp_q[CW-1:0];
					state_q <= S_USED;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						read_byte_q <= '0;
						last_q      <= 1'b1;
						moved_q     <= res_moved_q;
						readable_q  <= fill_q;
						writable_q  <= wr_q;
						history_q   <= back_q;
						state_q     <= S_IDLE;
					end
				end
				S_RD_ADDR: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= brb_pkg::STATUS_DATA;
						read_byte_q <= ram_rdata;
						last_q      <= (cnt_q == LW'(1));
						moved_q     <= res_moved_q;
						readable_q  <= fill_q;
						writable_q  <= wr_q;
						history_q   <= back_q;
						rp_q        <= alu_borrow ? alu_a[AW-1:0] : '0;
						cnt_q       <= cnt_q - LW'(1);
						state_q     <= (cnt_q == LW'(1)) ? S_IDLE : S_RD_ADDR;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_wr) begin
				unique case (brb_pkg::reg_index_t'(paddr[2]))
					brb_pkg::REG_CAPACITY: begin
						cap_q  <= cfg_val;
						size_q <= cfg_size;
						rp_q   <= '0;
						wp_q   <= '0;
						fill_q <= '0;
						back_q <= '0;
						pend_q <= '0;
					end
					brb_pkg::REG_HISTORY: begin
						hlim_q <= cfg_val;
						if (back_q > cfg_val) begin
							back_q <= cfg_val;
						end
					end
					default: begin
						hlim_q <= hlim_q;
					end
				endcase
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign read_byte      = read_byte_q;
	assign last           = last_q;
	assign moved          = moved_q;
	assign readable_count = readable_q;
	assign writable_count = writable_q;
	assign history_count  = history_q;

endmodule

>>> rtl/core/brb_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module brb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
